>>> sv/rhsv_pkg.sv
`default_nettype none
package rhsv_pkg;

    // Field and datapath widths
    localparam int PIX_W = 8;
    localparam int NUM_W = 17;
    localparam int DEN_W = 9;
    localparam int QUO_W = 8;
    localparam int DIF_W = PIX_W + 1;
    localparam int ARI_W = 19;

    // Two front stages, then one divider stage per quotient bit
    localparam int FRONT_STAGES = 2;
    localparam int PIPE_DEPTH   = FRONT_STAGES + QUO_W;

    // Hue sector offsets and scale factors, in degrees
    localparam logic signed [ARI_W-1:0] DEG_60  = 19'sd60;
    localparam logic signed [ARI_W-1:0] DEG_120 = 19'sd120;
    localparam logic signed [ARI_W-1:0] DEG_240 = 19'sd240;
    localparam logic signed [ARI_W-1:0] DEG_360 = 19'sd360;
    localparam logic [NUM_W-1:0]        SAT_FULL = 17'd255;

    // Channel holding the maximum; blue wins ties over green, green over red
    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } t_sector;

endpackage
`default_nettype wire

>>> sv/rhsv_in_if.sv
`default_nettype none
interface rhsv_in_if;
    import rhsv_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;

    modport source (output valid, output blue, output green, output red, input ready);
    modport sink   (input valid, input blue, input green, input red, output ready);
endinterface
`default_nettype wire

>>> sv/rhsv_out_if.sv
`default_nettype none
interface rhsv_out_if;
    import rhsv_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] hue;
    logic [PIX_W-1:0] saturation;
    logic [PIX_W-1:0] brightness;

    modport source (output valid, output hue, output saturation, output brightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                    output ready);
endinterface
`default_nettype wire

>>> sv/rhsv_prep.sv
`default_nettype none
module rhsv_prep (
    input  wire logic                        i_clk,
    input  wire logic                        i_en,
    input  wire logic [rhsv_pkg::PIX_W-1:0]  i_blue,
    input  wire logic [rhsv_pkg::PIX_W-1:0]  i_green,
    input  wire logic [rhsv_pkg::PIX_W-1:0]  i_red,
    output logic      [rhsv_pkg::NUM_W-1:0]  o_hue_num,
    output logic      [rhsv_pkg::DEN_W-1:0]  o_hue_den,
    output logic      [rhsv_pkg::NUM_W-1:0]  o_sat_num,
    output logic      [rhsv_pkg::DEN_W-1:0]  o_sat_den,
    output logic      [rhsv_pkg::PIX_W-1:0]  o_brightness
);
    import rhsv_pkg::*;

    logic [PIX_W-1:0]        mx;
    logic [PIX_W-1:0]        mn;
    t_sector                 sec;
    logic signed [DIF_W-1:0] diff;

    logic [PIX_W-1:0]        r_mx;
    logic [PIX_W-1:0]        r_c;
    t_sector                 r_sec;
    logic signed [DIF_W-1:0] r_diff;

    logic signed [ARI_W-1:0] base;
    logic signed [ARI_W-1:0] c_s;
    logic signed [ARI_W-1:0] diff_s;
    logic signed [ARI_W-1:0] num_s;

    logic [NUM_W-1:0] r_hue_num;
    logic [DEN_W-1:0] r_hue_den;
    logic [NUM_W-1:0] r_sat_num;
    logic [DEN_W-1:0] r_sat_den;
    logic [PIX_W-1:0] r_bri;

    // Find max, min and the sector of the maximum
    always_comb begin
        mx = (i_red > i_green) ? i_red : i_green;
        if (i_blue > mx) begin
            mx = i_blue;
        end
        mn = (i_red < i_green) ? i_red : i_green;
        if (i_blue < mn) begin
            mn = i_blue;
        end
        if (mx == i_blue) begin
            sec  = SEC_BLUE;
            diff = $signed({1'b0, i_red}) - $signed({1'b0, i_green});
        end else if (mx == i_green) begin
            sec  = SEC_GREEN;
            diff = $signed({1'b0, i_blue}) - $signed({1'b0, i_red});
        end else begin
            sec  = SEC_RED;
            diff = $signed({1'b0, i_green}) - $signed({1'b0, i_blue});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mx   <= mx;
            r_c    <= mx - mn;
            r_sec  <= sec;
            r_diff <= diff;
        end
    end

    // Form the hue numerator in degrees times chroma
    always_comb begin
        c_s    = $signed({{(ARI_W-PIX_W){1'b0}}, r_c});
        diff_s = $signed({{(ARI_W-DIF_W){r_diff[DIF_W-1]}}, r_diff});
        unique case (r_sec)
            SEC_BLUE:  base = DEG_240;
            SEC_GREEN: base = DEG_120;
            SEC_RED:   base = '0;
            default:   base = '0;
        endcase
        num_s = base * c_s + DEG_60 * diff_s;
        if (r_sec == SEC_RED && num_s < 0) begin
            num_s = num_s + DEG_360 * c_s;
        end
    end

    // Register dividend and divisor pairs; grey and black divide zero by a nonzero value
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hue_num <= num_s[NUM_W-1:0];
            r_hue_den <= (r_c == '0) ? DEN_W'(2) : {r_c, 1'b0};
            r_sat_num <= NUM_W'({{(NUM_W-PIX_W){1'b0}}, r_c} * SAT_FULL);
            r_sat_den <= (r_mx == '0) ? DEN_W'(1) : {1'b0, r_mx};
            r_bri     <= r_mx;
        end
    end

    assign o_hue_num    = r_hue_num;
    assign o_hue_den    = r_hue_den;
    assign o_sat_num    = r_sat_num;
    assign o_sat_den    = r_sat_den;
    assign o_brightness = r_bri;
endmodule
`default_nettype wire

>>> sv/rhsv_div.sv
`default_nettype none
module rhsv_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_en,
    input  wire logic [rhsv_pkg::NUM_W-1:0]  i_num,
    input  wire logic [rhsv_pkg::DEN_W-1:0]  i_den,
    output logic      [rhsv_pkg::QUO_W-1:0]  o_quo
);
    import rhsv_pkg::*;

    // Restoring divider, one quotient bit per stage, MSB first
    logic [NUM_W-1:0] r_rem [QUO_W];
    logic [DEN_W-1:0] r_den [QUO_W];
    logic [QUO_W-1:0] r_quo [QUO_W];

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        localparam int BIT = QUO_W - 1 - k;

        logic [NUM_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [QUO_W-1:0] quo_in;
        logic [NUM_W-1:0] dsh;
        logic             ge;

        if (k == 0) begin : g_first
            assign rem_in = i_num;
            assign den_in = i_den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign den_in = r_den[k-1];
            assign quo_in = r_quo[k-1];
        end

        // Compare against the shifted divisor and subtract on a hit
        assign dsh = {{(NUM_W-DEN_W){1'b0}}, den_in} << BIT;
        assign ge  = (rem_in >= dsh);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? (rem_in - dsh) : rem_in;
                r_den[k] <= den_in;
                r_quo[k] <= quo_in | (QUO_W'(ge) << BIT);
            end
        end
    end

    assign o_quo = r_quo[QUO_W-1];
endmodule
`default_nettype wire

>>> sv/rgb_to_hsv_pixel_top.sv
// Pipeline: two front stages (extremes, numerators), then two eight-stage
// restoring dividers that retire one quotient bit per stage.
// Throughput: one pixel word per cycle while the output side keeps taking words.
// Reset (synchronous, active low) clears the valid bits of every stage.
`default_nettype none
module rgb_to_hsv_pixel_top (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    rhsv_in_if.sink     i_pix,
    rhsv_out_if.source  o_hsv
);
    import rhsv_pkg::*;

    logic                  en;
    logic [PIPE_DEPTH-1:0] r_vld;
    logic [PIX_W-1:0]      r_bri [QUO_W];

    logic [NUM_W-1:0] hue_num;
    logic [DEN_W-1:0] hue_den;
    logic [NUM_W-1:0] sat_num;
    logic [DEN_W-1:0] sat_den;
    logic [PIX_W-1:0] bri;
    logic [QUO_W-1:0] hue_q;
    logic [QUO_W-1:0] sat_q;

    // Advance the whole pipe unless the last word is held by the sink
    assign en          = !r_vld[PIPE_DEPTH-1] || o_hsv.ready;
    assign i_pix.ready = en;

    // Shift valid bits along with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_pix.valid};
        end
    end

    rhsv_prep u_prep (
        .i_clk        (i_clk),
        .i_en         (en),
        .i_blue       (i_pix.blue),
        .i_green      (i_pix.green),
        .i_red        (i_pix.red),
        .o_hue_num    (hue_num),
        .o_hue_den    (hue_den),
        .o_sat_num    (sat_num),
        .o_sat_den    (sat_den),
        .o_brightness (bri)
    );

    rhsv_div u_hue_div (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (hue_num),
        .i_den (hue_den),
        .o_quo (hue_q)
    );

    rhsv_div u_sat_div (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (sat_num),
        .i_den (sat_den),
        .o_quo (sat_q)
    );

    // Delay brightness to line up with the divider outputs
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_bri[0] <= bri;
            for (int k = 1; k < QUO_W; k++) begin
                r_bri[k] <= r_bri[k-1];
            end
        end
    end

    assign o_hsv.valid      = r_vld[PIPE_DEPTH-1];
    assign o_hsv.hue        = hue_q;
    assign o_hsv.saturation = sat_q;
    assign o_hsv.brightness = r_bri[QUO_W-1];
endmodule
`default_nettype wire

>>> dv/rgb_to_hsv_pixel_top_tb.sv
`default_nettype none
module rgb_to_hsv_pixel_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rhsv_pkg::*;

    localparam int          RAND_WORDS  = 700;
    localparam int          EXP_DEPTH   = 1024;
    localparam int          TAIL_CYCLES = 3 * PIPE_DEPTH;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          REPORT_MAX  = 10;

    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
    } t_pix_word;

    typedef struct packed {
        logic [PIX_W-1:0] hue;
        logic [PIX_W-1:0] saturation;
        logic [PIX_W-1:0] brightness;
    } t_hsv_word;

    // One pixel waiting to be sent, with its lead-in gap and drain request
    typedef struct {
        t_pix_word   pix;
        int unsigned gap;
        bit          drain;
    } t_pix_job;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rhsv_in_if  pix_if ();
    rhsv_out_if hsv_if ();

    rgb_to_hsv_pixel_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .o_hsv   (hsv_if)
    );

    always #5 i_clk = ~i_clk;

    t_pix_job    pix_jobs[$];
    t_hsv_word   hsv_expected [0:EXP_DEPTH-1];
    int          pix_accepted_cnt = 0;
    int          hsv_seen_cnt     = 0;
    int          fault_cnt        = 0;
    int          cycle_cnt        = 0;
    bit          stim_done        = 1'b0;

    // Convert one pixel to hue, saturation and value
    function automatic t_hsv_word hsv_of(t_pix_word p);
        t_hsv_word res;
        t_sector   sec;
        int        b;
        int        g;
        int        r;
        int        vmax;
        int        vmin;
        int        chroma;
        int        deg_num;
        b = int'(p.blue);
        g = int'(p.green);
        r = int'(p.red);
        // Pick the sector; blue wins ties over green, green over red
        if (b >= g && b >= r) begin
            sec  = SEC_BLUE;
            vmax = b;
        end else if (g >= r) begin
            sec  = SEC_GREEN;
            vmax = g;
        end else begin
            sec  = SEC_RED;
            vmax = r;
        end
        vmin = (b < g) ? b : g;
        vmin = (r < vmin) ? r : vmin;
        chroma = vmax - vmin;
        res.brightness = vmax[PIX_W-1:0];
        res.saturation = '0;
        res.hue        = '0;
        if (vmax != 0) begin
            res.saturation = PIX_W'((255 * chroma) / vmax);
        end
        // Hue numerator is degrees times chroma, always non-negative here
        if (chroma != 0) begin
            case (sec)
                SEC_BLUE:  deg_num = 240 * chroma + 60 * (r - g);
                SEC_GREEN: deg_num = 120 * chroma + 60 * (b - r);
                default: begin
                    deg_num = 60 * (g - b);
                    if (deg_num < 0) begin
                        deg_num = deg_num + 360 * chroma;
                    end
                end
            endcase
            res.hue = PIX_W'(deg_num / (2 * chroma));
        end
        return res;
    endfunction

    function automatic t_pix_word mk_pix(int b, int g, int r);
        t_pix_word p;
        p.blue  = b[PIX_W-1:0];
        p.green = g[PIX_W-1:0];
        p.red   = r[PIX_W-1:0];
        return p;
    endfunction

    function automatic int clamp_chan(int v);
        return (v < 0) ? 0 : ((v > 255) ? 255 : v);
    endfunction

    // Mix plain random pixels with near-grey, tied, extreme and zero-channel ones
    function automatic t_pix_word random_pixel();
        int        roll;
        int        base;
        int        pick[4];
        t_pix_word p;
        roll = $urandom_range(99);
        p = mk_pix($urandom_range(255), $urandom_range(255), $urandom_range(255));
        if (roll < 50) begin
            return p;
        end else if (roll < 65) begin
            base = $urandom_range(255);
            return mk_pix(clamp_chan(base + $urandom_range(3) - $urandom_range(3)),
                          clamp_chan(base + $urandom_range(3) - $urandom_range(3)),
                          clamp_chan(base + $urandom_range(3) - $urandom_range(3)));
        end else if (roll < 80) begin
            case ($urandom_range(2))
                0:       p.green = p.blue;
                1:       p.red   = p.green;
                default: p.blue  = p.red;
            endcase
            return p;
        end else if (roll < 90) begin
            pick = '{0, 1, 254, 255};
            return mk_pix(pick[$urandom_range(3)], pick[$urandom_range(3)],
                          pick[$urandom_range(3)]);
        end else begin
            case ($urandom_range(2))
                0:       p.blue  = '0;
                1:       p.green = '0;
                default: p.red   = '0;
            endcase
            return p;
        end
    endfunction

    // Mostly back-to-back, often short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 55) begin
            return 0;
        end else if (roll < 93) begin
            return $urandom_range(3, 1);
        end else begin
            return $urandom_range(40, 12);
        end
    endfunction

    task automatic add_job(t_pix_word p, int unsigned gap, bit drain);
        t_pix_job job;
        job.pix   = p;
        job.gap   = gap;
        job.drain = drain;
        pix_jobs.push_back(job);
    endtask

    // Feed pixel words; predict each one as it is taken
    int unsigned idle_left = 0;
    bit          gap_taken = 1'b0;
    t_pix_word   pix_on_bus;

    always @(posedge i_clk) begin
        int       acc_now;
        bit       fire;
        t_pix_job job;
        if (!i_rst_n) begin
            pix_if.valid <= 1'b0;
            pix_if.blue  <= '0;
            pix_if.green <= '0;
            pix_if.red   <= '0;
        end else begin
            fire    = pix_if.valid && pix_if.ready;
            acc_now = pix_accepted_cnt + (fire ? 1 : 0);
            if (fire) begin
                hsv_expected[pix_accepted_cnt % EXP_DEPTH] <= hsv_of(pix_on_bus);
                pix_accepted_cnt <= acc_now;
            end
            // Hold the word until it is taken
            if (!pix_if.valid || fire) begin
                if (pix_jobs.size() == 0) begin
                    pix_if.valid <= 1'b0;
                    stim_done    <= 1'b1;
                end else begin
                    if (!gap_taken) begin
                        idle_left = pix_jobs[0].gap;
                        gap_taken = 1'b1;
                    end
                    if (idle_left > 0) begin
                        idle_left--;
                        pix_if.valid <= 1'b0;
                    end else if (pix_jobs[0].drain && hsv_seen_cnt != acc_now) begin
                        pix_if.valid <= 1'b0;
                    end else begin
                        job        = pix_jobs.pop_front();
                        pix_on_bus = job.pix;
                        gap_taken  = 1'b0;
                        pix_if.valid <= 1'b1;
                        pix_if.blue  <= job.pix.blue;
                        pix_if.green <= job.pix.green;
                        pix_if.red   <= job.pix.red;
                    end
                end
            end
        end
    end

    // Take result words, check them against the oldest prediction, stall at random
    int unsigned ready_left  = 0;
    logic        ready_level = 1'b1;

    always @(posedge i_clk) begin
        t_hsv_word want;
        int        roll;
        if (!i_rst_n) begin
            hsv_if.ready <= 1'b0;
        end else begin
            if (hsv_if.valid && hsv_if.ready) begin
                if (hsv_seen_cnt >= pix_accepted_cnt) begin
                    if (fault_cnt < REPORT_MAX) begin
                        $display("[%0t] unexpected result word hue=%0d sat=%0d val=%0d",
                                 $realtime, hsv_if.hue, hsv_if.saturation,
                                 hsv_if.brightness);
                    end
                    fault_cnt <= fault_cnt + 1;
                end else begin
                    want = hsv_expected[hsv_seen_cnt % EXP_DEPTH];
                    if (hsv_if.hue !== want.hue ||
                        hsv_if.saturation !== want.saturation ||
                        hsv_if.brightness !== want.brightness) begin
                        if (fault_cnt < REPORT_MAX) begin
                            $display("[%0t] word %0d: exp %0d/%0d/%0d got %0d/%0d/%0d",
                                     $realtime, hsv_seen_cnt, want.hue, want.saturation,
                                     want.brightness, hsv_if.hue, hsv_if.saturation,
                                     hsv_if.brightness);
                        end
                        fault_cnt <= fault_cnt + 1;
                    end
                    hsv_seen_cnt <= hsv_seen_cnt + 1;
                end
            end
            // Pick the next ready stretch when the current one runs out
            if (ready_left == 0) begin
                roll = $urandom_range(99);
                if (roll < 15) begin
                    ready_level = 1'b1;
                    ready_left  = $urandom_range(150, 50);
                end else if (roll < 65) begin
                    ready_level = 1'b1;
                    ready_left  = $urandom_range(8, 1);
                end else if (roll < 95) begin
                    ready_level = 1'b0;
                    ready_left  = $urandom_range(3, 1);
                end else begin
                    ready_level = 1'b0;
                    ready_left  = $urandom_range(40, 12);
                end
            end
            ready_left--;
            hsv_if.ready <= ready_level;
        end
    end

    // Abort a run that hangs
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;

        // Directed words: black, white, grey, primaries, ties, hue wrap, small chroma
        add_job(mk_pix(  0,   0,   0), 0, 1'b0);
        add_job(mk_pix(255, 255, 255), 0, 1'b0);
        add_job(mk_pix(128, 128, 128), 0, 1'b0);
        add_job(mk_pix(  1,   1,   1), 0, 1'b0);
        add_job(mk_pix(  0,   0, 255), 0, 1'b0);
        add_job(mk_pix(  0, 255,   0), 0, 1'b0);
        add_job(mk_pix(255,   0,   0), 0, 1'b0);
        add_job(mk_pix(255, 255,   0), 1, 1'b0);
        add_job(mk_pix(  0, 255, 255), 0, 1'b0);
        add_job(mk_pix(255,   0, 255), 0, 1'b0);
        add_job(mk_pix( 90,  40,  90), 2, 1'b0);
        add_job(mk_pix(  1,   0, 255), 0, 1'b0);
        add_job(mk_pix(254,   0, 255), 0, 1'b0);
        add_job(mk_pix(  0,   0,   1), 0, 1'b0);
        add_job(mk_pix(  0,   1,   0), 0, 1'b0);
        add_job(mk_pix(  1,   0,   0), 0, 1'b0);
        add_job(mk_pix(255, 254, 255), 3, 1'b0);
        add_job(mk_pix(254, 255, 255), 0, 1'b0);
        add_job(mk_pix(  0, 127, 128), 0, 1'b0);
        add_job(mk_pix(170,  85, 170), 0, 1'b0);
        add_job(mk_pix( 85, 170,  85), 0, 1'b0);
        add_job(mk_pix(255, 128,   0), 0, 1'b0);
        add_job(mk_pix(  1, 255,   0), 0, 1'b0);

        // Random words; drain the pipe first, keep a stretch back-to-back, drain again
        for (int i = 0; i < RAND_WORDS; i++) begin
            add_job(random_pixel(), (i >= 150 && i < 250) ? 0 : pick_gap(),
                    (i == 0 || i == 350));
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for the last word to go out, then for every result
        while (!stim_done) @(posedge i_clk);
        while (hsv_seen_cnt != pix_accepted_cnt) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fault_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
